// File: rtl/core/dmx512_slot_window_receiver_unit_macros.svh
// Assertion macros shared by the DMX512 slot-window receiver RTL.
`ifndef DMX512_SLOT_WINDOW_RECEIVER_UNIT_MACROS_SVH
`define DMX512_SLOT_WINDOW_RECEIVER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define DSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DSW_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/dmxswr_pkg.sv
// Types and constants of the DMX512 slot-window receiver.
package dmxswr_pkg;

   localparam int SLOT_W = 10;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 3;
   localparam int MAX_READ_DEPTH = 2 ** IDX_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = 10'd512;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_START_ADDRESS = 1'b0;

   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_value;
      logic              stored;
      logic [IDX_W-1:0]  stored_index;
      logic              start_code_seen;
      logic              window_complete_on_break;
   } rsp_type;

endpackage

// File: rtl/core/dmx512_slot_window_receiver_unit.sv
// DMX512 slot-window receiver: slot counting, window capture and channel readback.
//
// Usage: each req item is either a received UART byte with its first stop bit
// (operation byte) or a read of one captured channel (operation read). Every
// item gives exactly one rsp item. A byte with a clear stop bit is a break that
// restarts the frame and reports whether the frame had passed the window. A zero
// start code at slot 0 opens capture, and bytes whose slots fall in the window
// that starts at start_address are written into the channel store.
// rsp valid comes from the result register: an item passes one input register, then
// one pass of compare and counter logic into the result register. Throughput is one
// item per cycle while rsp_ready stays high, set by the single result register stage.
// When the receiver holds rsp_ready low, the result stays and the input register
// still takes one more item; after that req_ready falls until the rsp is taken.
// Reset clears the slot counter, the frame flag, start_address and the store.
// start_address is written over the APB-style port at byte address 0.
`include "dmx512_slot_window_receiver_unit_macros.svh"

module dmx512_slot_window_receiver_unit #(
   parameter int CHANNELS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_operation,
   input  logic [dmxswr_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                   req_stop_bit_ok,
   input  logic [dmxswr_pkg::IDX_W-1:0]           req_channel_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dmxswr_pkg::BYTE_W-1:0]          rsp_read_value,
   output logic                                   rsp_stored,
   output logic [dmxswr_pkg::IDX_W-1:0]           rsp_stored_index,
   output logic                                   rsp_start_code_seen,
   output logic                                   rsp_window_complete_on_break,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [dmxswr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [dmxswr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [dmxswr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                   pready
);
   import dmxswr_pkg::*;

   localparam int STORE_DEPTH = (CHANNELS < MAX_READ_DEPTH) ? CHANNELS : MAX_READ_DEPTH;
   localparam int END_W = $clog2((2 ** SLOT_W) + CHANNELS);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic              op_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              stop_ok_ff;
   logic [IDX_W-1:0]  ch_ff;

   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic              frame_valid_ff;
   logic              frame_valid_in;
   logic [SLOT_W-1:0] start_ff;
   logic [SLOT_W-1:0] start_in;
   logic [BYTE_W-1:0] store_ff [STORE_DEPTH];

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              advance;
   logic              fire;
   logic              store_wr;
   logic [SLOT_W-1:0] slot_diff;
   logic [END_W-1:0]  win_end;
   logic              in_window;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[CSR_ADDR_W-1] == REG_START_ADDRESS) ?
                      CSR_DATA_W'(start_ff) : '0;
   assign start_in  = (csr_write && paddr[CSR_ADDR_W-1] == REG_START_ADDRESS) ?
                      pwdata[SLOT_W-1:0] : start_ff;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign fire        = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign slot_diff = slot_ff - start_ff;
   assign win_end   = END_W'(start_ff) + END_W'(CHANNELS);
   assign in_window = (slot_ff >= start_ff) && (END_W'(slot_ff) < win_end);

   always_comb begin
      rsp_in         = '0;
      slot_in        = slot_ff;
      frame_valid_in = frame_valid_ff;
      store_wr       = 1'b0;
      if (op_ff == OP_READ) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (ch_ff == IDX_W'(i)) begin
               rsp_in.read_value = store_ff[i];
            end
         end
      end else if (stop_ok_ff) begin
         if (slot_ff == '0 && byte_ff == '0) begin
            frame_valid_in         = 1'b1;
            rsp_in.start_code_seen = 1'b1;
         end else if (frame_valid_ff && in_window) begin
            store_wr            = 1'b1;
            rsp_in.stored       = 1'b1;
            rsp_in.stored_index = slot_diff[IDX_W-1:0];
         end
         if (slot_ff == LAST_SLOT) begin
            slot_in        = '0;
            frame_valid_in = 1'b0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end else begin
         rsp_in.window_complete_on_break = (END_W'(slot_ff) >= win_end);
         slot_in        = '0;
         frame_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         op_ff      <= req_operation;
         byte_ff    <= req_rx_byte;
         stop_ok_ff <= req_stop_bit_ok;
         ch_ff      <= req_channel_index;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         slot_ff        <= '0;
         frame_valid_ff <= 1'b0;
         start_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         if (fire) begin
            slot_ff        <= slot_in;
            frame_valid_ff <= frame_valid_in;
         end
      end
   end

   for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_store
      always_ff @(posedge clock) begin
         if (reset) begin
            store_ff[g] <= '0;
         end else if (fire && store_wr && slot_diff == SLOT_W'(g)) begin
            store_ff[g] <= byte_ff;
         end
      end
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_read_value               = rsp_ff.read_value;
   assign rsp_stored                   = rsp_ff.stored;
   assign rsp_stored_index             = rsp_ff.stored_index;
   assign rsp_start_code_seen          = rsp_ff.start_code_seen;
   assign rsp_window_complete_on_break = rsp_ff.window_complete_on_break;

   `DSW_ASSERT_SAME(a_slot_range, clock, reset, 1'b1, slot_ff <= LAST_SLOT,
      "slot counter beyond last slot")
   `DSW_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_ff.stored && rsp_ff.start_code_seen) &&
      !(rsp_ff.stored && rsp_ff.window_complete_on_break),
      "conflicting result flags")
   `DSW_ASSERT_NEXT(a_break_clears, clock, reset, fire && op_ff == OP_BYTE && !stop_ok_ff,
      slot_ff == '0 && !frame_valid_ff, "break did not restart the frame")

endmodule
